FILE: src/complex_domain_onset_detector_unit_defines.svh
// Assertion macros used by the checker file
`ifndef COMPLEX_DOMAIN_ONSET_DETECTOR_UNIT_DEFINES_SVH
`define COMPLEX_DOMAIN_ONSET_DETECTOR_UNIT_DEFINES_SVH
// assert that an antecedent implies a consequent in the same cycle
`define CDOD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// assert that an antecedent implies a consequent in the next cycle
`define CDOD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: src/cdod_pkg.sv
// ---------------------------------------------------------------------------
// cdod_pkg
// Types, constants and helpers of the complex-domain onset detector.
// ---------------------------------------------------------------------------
package cdod_pkg;
    localparam int unsigned CORDIC_ITERS = 16;
    localparam int unsigned GAIN_INV     = 39797;
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned CFG_DATA_W   = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_RECTIFY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS    = 1'b1;
    localparam logic [10:0] BINS_RESET = 11'd513;
    localparam int unsigned SUM_W  = 27;
    localparam int unsigned DIST_W = 17;
    localparam int unsigned OUT_W  = 17;

    // arctangent table, 2^-24 turn units
    function automatic logic [21:0] atan_lut(input logic [3:0] i);
        logic [21:0] v;
        case (i)
            4'd0:  v = 22'd2097152;
            4'd1:  v = 22'd1238021;
            4'd2:  v = 22'd654136;
            4'd3:  v = 22'd332050;
            4'd4:  v = 22'd166669;
            4'd5:  v = 22'd83416;
            4'd6:  v = 22'd41718;
            4'd7:  v = 22'd20860;
            4'd8:  v = 22'd10430;
            4'd9:  v = 22'd5215;
            4'd10: v = 22'd2608;
            4'd11: v = 22'd1304;
            4'd12: v = 22'd652;
            4'd13: v = 22'd326;
            4'd14: v = 22'd163;
            4'd15: v = 22'd81;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_VEC1  = 8'b0000_0010,
        S_ROT   = 8'b0000_0100,
        S_DESC  = 8'b0000_1000,
        S_VEC2  = 8'b0001_0000,
        S_ACC   = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;
endpackage

FILE: src/cdod_stream_if.sv
// ---------------------------------------------------------------------------
// cdod_stream_if
// Valid/ready channel carrying a generic payload.
// ---------------------------------------------------------------------------
interface cdod_stream_if #(
    parameter int unsigned WIDTH = 32
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/cdod_ram.sv
// ---------------------------------------------------------------------------
// cdod_ram
// Single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module cdod_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

FILE: src/cdod_cordic.sv
// ---------------------------------------------------------------------------
// cdod_cordic
// Iterative CORDIC, one micro-rotation a cycle, vectoring or rotating mode.
// Operands are pre-scaled by 4; gain removed outside.
// ---------------------------------------------------------------------------
module cdod_cordic
    import cdod_pkg::*;
#(
    parameter int unsigned XW = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_rotate,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [25:0]   i_z,
    output logic                 o_done,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [25:0]   o_z
);
    logic signed [XW-1:0] r_x, r_y;
    logic signed [25:0]   r_z;
    logic [3:0]           r_i;
    logic                 r_busy, r_rot, r_done;
    logic signed [XW-1:0] xs, ys;
    logic signed [25:0]   at;
    logic                 dir_pos;

    always_comb begin
        xs      = r_x >>> r_i;
        ys      = r_y >>> r_i;
        at      = $signed({4'd0, atan_lut(r_i)});
        dir_pos = r_rot ? (r_z >= 0) : (r_y < 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_x;
                r_y    <= i_y;
                r_z    <= i_z;
                r_rot  <= i_rotate;
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // counterclockwise when rotating toward positive z or vectoring y<0
                if (dir_pos) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
                r_i <= r_i + 4'd1;
                if (r_i == 4'(CORDIC_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
endmodule

FILE: src/complex_domain_onset_detector_unit.sv
// Each bin request is followed by a busy sequence (setup, three 16-step CORDIC passes
// on one shared unit, restart, write-back); no new request is accepted until it ends.
// From the third frame on, the last bin of a frame then runs a 27-step mean division
// and the output register before its result is valid. A pending result blocks input.
// Reset clears control state, configuration registers, bin position, frame counter and
// running sum; the magnitude and phase memories are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
// complex_domain_onset_detector_unit
// Per-bin complex-domain prediction error accumulated into a frame mean.
// ---------------------------------------------------------------------------
module complex_domain_onset_detector_unit
    import cdod_pkg::*;
#(
    parameter int unsigned MAX_BINS    = 1024,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cdod_stream_if.sink           bin_in,
    cdod_stream_if.source         onset_out
);
    localparam int unsigned AW = $clog2(MAX_BINS);
    localparam int unsigned XW = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 8;
    localparam int unsigned VW = 2 * XW + 26;

    logic        r_rect;
    logic [10:0] r_bins;
    logic [11:0] nbins_c;
    always_comb begin
        if (r_bins == 11'd0) nbins_c = 12'd1;
        else if (13'(r_bins) > 13'(MAX_BINS)) nbins_c = 12'(MAX_BINS);
        else nbins_c = {1'b0, r_bins};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect <= 1'b0;
            r_bins <= BINS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RECTIFY: r_rect <= i_cfg_data[0];
                CFG_BINS:    r_bins <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_state r_state;
    logic signed [SAMPLE_BITS-1:0] r_re, r_im;
    logic [AW-1:0]  r_pos;
    logic [1:0]     r_frames;
    logic [SUM_W-1:0] r_sum;
    logic [15:0]    r_mag, r_ph;
    logic           r_last;
    logic [1:0]     r_dstep;
    logic signed [XW-1:0] r_pr, r_pi;
    logic [SUM_W-1:0] r_quo, r_rem;
    logic [4:0]     r_dcnt;
    logic [OUT_W-1:0] r_out;
    logic           r_ovalid;

    // memories
    logic           mem_we;
    logic [15:0]    lm_rd, lp_rd, op_rd;
    cdod_ram #(.WIDTH(16), .DEPTH(MAX_BINS)) u_lmag (
        .i_clk, .i_we(mem_we), .i_waddr(r_pos), .i_wdata(r_mag),
        .i_raddr(r_pos), .o_rdata(lm_rd));
    cdod_ram #(.WIDTH(16), .DEPTH(MAX_BINS)) u_lph (
        .i_clk, .i_we(mem_we), .i_waddr(r_pos), .i_wdata(r_ph),
        .i_raddr(r_pos), .o_rdata(lp_rd));
    cdod_ram #(.WIDTH(16), .DEPTH(MAX_BINS)) u_oph (
        .i_clk, .i_we(mem_we), .i_waddr(r_pos), .i_wdata(lp_rd),
        .i_raddr(r_pos), .o_rdata(op_rd));

    // shared CORDIC
    logic                 c_start, c_rot, c_done;
    logic signed [XW-1:0] c_xi, c_yi, c_xo, c_yo;
    logic signed [25:0]   c_zi, c_zo;
    cdod_cordic #(.XW(XW)) u_cordic (
        .i_clk, .i_rst_n, .i_start(c_start), .i_rotate(c_rot),
        .i_x(c_xi), .i_y(c_yi), .i_z(c_zi), .o_done(c_done),
        .o_x(c_xo), .o_y(c_yo), .o_z(c_zo));

    // descale: |v|*GAIN_INV rounded, 18-bit shift
    function automatic logic signed [XW-1:0] descale(input logic signed [XW-1:0] v);
        logic [XW-1:0]  a;
        logic [XW+15:0] p;
        logic [XW-1:0]  r;
        a = v[XW-1] ? XW'(-v) : v;
        p = (XW+16)'(a) * (XW+16)'(GAIN_INV) + (XW+16)'(1 << 17);
        r = XW'(p >> 18);
        return v[XW-1] ? $signed(-r) : $signed(r);
    endfunction

    logic [AW:0] pos_n1;
    assign pos_n1 = {1'b0, r_pos} + 1'b1;

    // vectoring input setup with half-turn fold
    function automatic logic [VW-1:0] vec_in(input logic signed [XW-1:0] x,
                                             input logic signed [XW-1:0] y);
        logic signed [XW-1:0] xx, yy;
        logic signed [25:0]   z;
        xx = x <<< 2;
        yy = y <<< 2;
        z  = '0;
        if (xx < 0) begin
            xx = -xx;
            yy = -yy;
            z  = 26'sd8388608;
        end
        return {xx, yy, z};
    endfunction

    logic [15:0] pph, rot_a;
    logic        rot_flip;
    logic [VW-1:0] vsetup;
    logic signed [XW-1:0] mag_d, pr_d, pi_d, dx, dy;
    logic [16:0]  dist_c;
    logic [SUM_W:0] sum_add;
    logic [15:0]  ph_c;
    logic [SUM_W:0] rem_sh;

    always_comb begin
        pph      = 16'(2 * lp_rd) - op_rd;
        rot_flip = (pph >= 16'h4000) && (pph < 16'hC000);
        rot_a    = rot_flip ? pph - 16'h8000 : pph;
        ph_c     = 16'((c_zo + 26'sd128) >>> 8);
        mag_d    = descale(c_xo);
        pr_d     = rot_flip ? -descale(c_xo) : descale(c_xo);
        pi_d     = rot_flip ? -descale(c_yo) : descale(c_yo);
        dx       = r_pr - XW'(r_re);
        dy       = r_pi - XW'(r_im);
        vsetup   = vec_in(XW'(r_re), XW'(r_im));
        dist_c   = (mag_d > XW'(131071)) ? 17'd131071 : 17'(mag_d);
        sum_add  = {1'b0, r_sum} + (SUM_W+1)'(dist_c);
        rem_sh   = {r_rem, r_quo[SUM_W-1]};
        c_start  = 1'b0;
        c_rot    = 1'b0;
        c_xi     = vsetup[VW-1 -: XW];
        c_yi     = vsetup[26 +: XW];
        c_zi     = vsetup[25:0];
        mem_we   = 1'b0;
        if (r_state == S_ROT) c_start = 1'b1;
        if (r_state == S_VEC1 && c_done) begin
            c_start = 1'b1;
            c_rot   = 1'b1;
            c_xi    = XW'({1'b0, lm_rd}) <<< 2;
            c_yi    = '0;
            c_zi    = 26'($signed(rot_a)) <<< 8;
        end
        if (r_state == S_DESC) begin
            c_start = 1'b1;
            vsetup  = vec_in(dx, dy);
            c_xi    = vsetup[VW-1 -: XW];
            c_yi    = vsetup[26 +: XW];
            c_zi    = vsetup[25:0];
        end
        if (r_state == S_ACC) mem_we = 1'b1;
    end

    assign bin_in.ready = (r_state == S_IDLE) && !r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_frames <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (onset_out.valid && onset_out.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (bin_in.valid && bin_in.ready) begin
                        r_re    <= $signed(bin_in.data[2*SAMPLE_BITS-1:SAMPLE_BITS]);
                        r_im    <= $signed(bin_in.data[SAMPLE_BITS-1:0]);
                        r_state <= S_ROT;
                        if ({1'b0, r_pos} >= (AW+1)'(MAX_BINS - 1))
                            r_pos <= AW'(MAX_BINS - 1);
                    end
                end
                S_ROT: begin
                    // first pass start, from the registered sample
                    r_state <= S_VEC1;
                end
                S_VEC1: begin
                    if (c_done) begin
                        r_mag   <= (mag_d > XW'(65535)) ? 16'hFFFF : 16'(mag_d);
                        r_ph    <= ph_c;
                        r_last  <= (pos_n1 >= (AW+1)'(nbins_c));
                        r_dstep <= 2'd0;
                        r_state <= S_VEC2;
                    end
                end
                S_VEC2: begin
                    if (c_done) begin
                        if (r_dstep == 2'd0) begin
                            r_pr    <= pr_d;
                            r_pi    <= pi_d;
                            r_dstep <= 2'd1;
                            r_state <= S_DESC;
                        end else begin
                            if (r_frames == 2'd2 && !(r_rect && lm_rd > r_mag)) begin
                                r_sum <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                            end
                            r_state <= S_ACC;
                        end
                    end
                end
                S_DESC: r_state <= S_VEC2;
                S_ACC: begin
                    if (r_last) begin
                        r_pos <= '0;
                        if (r_frames == 2'd2) begin
                            r_quo   <= r_sum;
                            r_rem   <= '0;
                            r_dcnt  <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_frames <= r_frames + 2'd1;
                            r_sum    <= '0;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        r_pos   <= pos_n1[AW-1:0];
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (rem_sh >= (SUM_W+1)'(nbins_c)) begin
                        r_rem <= SUM_W'(rem_sh - (SUM_W+1)'(nbins_c));
                        r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                    end else begin
                        r_rem <= SUM_W'(rem_sh);
                        r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'(SUM_W - 1)) r_state <= S_OUT;
                end
                S_OUT: begin
                    r_out    <= r_quo[OUT_W-1:0];
                    r_ovalid <= 1'b1;
                    r_sum    <= '0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign onset_out.valid = r_ovalid;
    assign onset_out.data  = r_out;
endmodule

FILE: src/cdod_checker.sv
// ---------------------------------------------------------------------------
// cdod_checker
// Port-level checks of the onset detector.
// ---------------------------------------------------------------------------
`include "complex_domain_onset_detector_unit_defines.svh"
module cdod_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [16:0] out_data
);
    `CDOD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
    `CDOD_ASSERT_NEXT(a_data_hold, i_clk, i_rst_n, out_valid && !out_ready, $stable(out_data))
    `CDOD_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
    `CDOD_ASSERT_IMPL(a_no_req_while_pending, i_clk, i_rst_n, out_valid, !in_ready)
endmodule

bind complex_domain_onset_detector_unit cdod_checker u_cdod_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(bin_in.valid), .in_ready(bin_in.ready),
    .out_valid(onset_out.valid), .out_ready(onset_out.ready),
    .out_data(onset_out.data));
